/* rtl/dtf_pkg.sv */
// ----------------------------------------------------------------------------
// dtf_pkg: shared types and constants for the double to five-byte float block
// Field positions of the double, result codes and the result record.
// ----------------------------------------------------------------------------
package dtf_pkg;

	localparam int FracBits = 52;
	localparam int ExpBits  = 11;

	localparam logic [ExpBits-1:0] ExpAllOnes  = 11'h7FF;
	localparam logic [ExpBits-1:0] ExpZeroPt   = 11'd1023;
	localparam logic [ExpBits-1:0] ExpSmallTop = 11'd1038; // 1023 + 15
	// valid biased double exponents: e = k+1 in -128..127 -> efield 894..1149
	localparam logic [ExpBits-1:0] ExpLowest   = 11'd894;
	localparam logic [ExpBits-1:0] ExpHighest  = 11'd1149;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_RANGE   = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  exponent_byte;
		logic [31:0] mantissa_bits;
	} result_t;

endpackage

/* rtl/double_to_five_byte_float.sv */
// ----------------------------------------------------------------------------
// double_to_five_byte_float: IEEE double to five-byte float converter
// Input register, one conversion stage, output register with valid/ready.
// ----------------------------------------------------------------------------
// The input register holds the accepted request; its converted result is then
// loaded into the result register, which drives out_valid and the outputs.
// Throughput: one request per cycle unless out_ready stalls the result; conversion
// logic sits between the input register and the result register.
// Reset: arst_n asynchronously clears both stage valid bits.
module double_to_five_byte_float (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] value_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  exponent_byte,
	output logic [31:0] mantissa_bits
);

	logic             v_s1, v_s2;
	logic [63:0]      value_s1;
	dtf_pkg::result_t res_c, res_s2;
	logic             adv2, adv1;

	assign adv2     = !v_s2 || out_ready;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	dtf_convert u_conv (.value_bits(value_s1), .res(res_c));

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) value_s1 <= value_bits;
		if (adv2 && v_s1) res_s2 <= res_c;
	end

	assign out_valid     = v_s2;
	assign status        = res_s2.status;
	assign exponent_byte = res_s2.exponent_byte;
	assign mantissa_bits = res_s2.mantissa_bits;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_s2))
		else $error("result changed while stalled");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != dtf_pkg::ST_OK
		|-> exponent_byte == 8'd0 && mantissa_bits == 32'd0)
		else $error("error result carries data");
	a_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && exponent_byte != 8'd0 |-> !mantissa_bits[31])
		else $error("mantissa top bit set");

endmodule

/* rtl/dtf_convert.sv */
// ----------------------------------------------------------------------------
// dtf_convert: combinational conversion of one double pattern
// Classifies the value, builds the short integer form or the rounded form.
// ----------------------------------------------------------------------------
module dtf_convert (
	input  logic [63:0]     value_bits,
	output dtf_pkg::result_t res
);

	logic [10:0] efield;
	logic [51:0] frac;
	logic [52:0] sig;
	logic [3:0]  kk;
	logic [52:0] int_sh;
	logic [51:0] low_mask;
	logic        whole;
	logic [15:0] t;
	logic [31:0] m;
	logic [7:0]  eb;

	assign efield = value_bits[62:52];
	assign frac   = value_bits[51:0];
	assign sig    = {1'b1, frac};
	assign kk     = 4'(efield - dtf_pkg::ExpZeroPt);
	assign int_sh = sig >> (6'd52 - {2'b00, kk});
	assign low_mask = ~(52'hF_FFFF_FFFF_FFFF << (6'd52 - {2'b00, kk}));
	assign t = int_sh[15:0];
	assign m = sig[52:21];
	// 128 + efield - 1022, modulo 256
	assign eb = 8'(efield + 11'd130);

	always_comb begin
		res = '{status: dtf_pkg::ST_OK, exponent_byte: 8'd0, mantissa_bits: 32'd0};
		whole = (efield >= dtf_pkg::ExpZeroPt) && (efield <= dtf_pkg::ExpSmallTop)
			&& ((frac & low_mask) == 52'd0);
		if (efield == dtf_pkg::ExpAllOnes) begin
			res.status = dtf_pkg::ST_INVALID;
		end else if (efield == 11'd0) begin
			if (frac != 52'd0) res.status = dtf_pkg::ST_RANGE;
		end else if (whole) begin
			res.mantissa_bits = {8'd0, t[7:0], t[15:8], 8'd0};
		end else if (efield < dtf_pkg::ExpLowest || efield > dtf_pkg::ExpHighest) begin
			res.status = dtf_pkg::ST_RANGE;
		end else begin
			res.exponent_byte = eb;
			// round up by the next bit unless all ones; top bit cleared
			if (sig[20] && m != 32'hFFFF_FFFF)
				res.mantissa_bits = {1'b0, 31'(m + 32'd1)};
			else
				res.mantissa_bits = {1'b0, m[30:0]};
		end
	end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for the double to five-byte float converter
// Drives double bit patterns through the request channel, predicts each
// five-byte float and compares it field by field with the block's results.
// ----------------------------------------------------------------------------
module tb;

	localparam int MaxCycles = 400000;
	localparam int HoldLen   = 60;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] value_bits;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [7:0]  exponent_byte;
	logic [31:0] mantissa_bits;

	dtf_pkg::result_t pending_q[$];
	int          mismatch_cnt = 0;
	int          cycle_cnt = 0;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_cycles = 0;
	int          hold_req_cnt;
	int          hold_seen_cnt = 0;

	double_to_five_byte_float u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .value_bits(value_bits),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .exponent_byte(exponent_byte), .mantissa_bits(mantissa_bits)
	);

	// clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > MaxCycles) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// expected five-byte float for one double pattern
	function automatic dtf_pkg::result_t convert_double(logic [63:0] v);
		dtf_pkg::result_t r;
		logic [10:0] ef;
		logic [51:0] frac;
		logic [52:0] sig;
		logic [31:0] m;
		int          k;
		int          e;
		int          sh;
		logic [15:0] t;
		bit          whole;
		ef = v[62:52];
		frac = v[51:0];
		sig = {1'b1, frac};
		r.status = dtf_pkg::ST_OK;
		r.exponent_byte = 8'd0;
		r.mantissa_bits = 32'd0;
		whole = 1'b0;
		if (ef == 11'h7FF) begin
			r.status = dtf_pkg::ST_INVALID;
		end else if (ef == 11'd0) begin
			if (frac != 52'd0)
				r.status = dtf_pkg::ST_RANGE;
		end else begin
			k = int'(ef) - 1023;
			if (k >= 0 && k <= 15) begin
				sh = 52 - k;
				whole = ((frac << (52 - sh)) == 52'd0) || (sh == 52 && frac == 52'd0);
				if (sh == 52)
					whole = (frac == 52'd0);
				if (whole) begin
					t = 16'(sig >> sh);
					r.mantissa_bits = {8'd0, t[7:0], t[15:8], 8'd0};
				end
			end
			if (!whole) begin
				e = k + 1;
				if (e < -128 || e > 127) begin
					r.status = dtf_pkg::ST_RANGE;
				end else begin
					m = sig[52:21];
					if (sig[20] && m != 32'hFFFF_FFFF)
						m = m + 32'd1;
					r.mantissa_bits = {1'b0, m[30:0]};
					r.exponent_byte = 8'(128 + e);
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		mismatch_cnt++;
	endtask

	// result checker
	always @(posedge clk) begin
		dtf_pkg::result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected result",
					64'({status, exponent_byte, mantissa_bits}), 64'd0);
			end else begin
				exp_r = pending_q.pop_front();
				if (status != exp_r.status)
					report_mismatch("status", 64'(status), 64'(exp_r.status));
				if (exponent_byte != exp_r.exponent_byte)
					report_mismatch("exponent_byte", 64'(exponent_byte),
						64'(exp_r.exponent_byte));
				if (mantissa_bits != exp_r.mantissa_bits)
					report_mismatch("mantissa_bits", 64'(mantissa_bits),
						64'(exp_r.mantissa_bits));
			end
		end
	end

	// receiver: random stalls, long hold on request from a test
	always @(negedge clk) begin
		if (hold_req_cnt != hold_seen_cnt) begin
			hold_seen_cnt <= hold_req_cnt;
			hold_cycles <= HoldLen;
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// send one request; valid stays high through back-to-back requests
	task automatic send_request(logic [63:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		value_bits <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_q.push_back(convert_double(v));
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [63:0] make_double(bit sgn, int ef, logic [51:0] frac);
		return {sgn, 11'(ef), frac};
	endfunction

	task automatic test_directed();
		send_request(64'h0000_0000_0000_0000);           // +0
		send_request(64'h8000_0000_0000_0000);           // -0
		send_request(64'h3FF0_0000_0000_0000);           // 1
		send_request(64'h40EF_FFE0_0000_0000);           // 65535
		send_request(64'h40F0_0000_0000_0000);           // 65536
		send_request(64'hC0EF_FFE0_0000_0000);           // -65535
		send_request(64'h3FE0_0000_0000_0000);           // 0.5
		send_request(64'h3FF8_0000_0000_0000);           // 1.5
		send_request(64'h4000_0000_0000_0001);           // near 2, not whole
		send_request(64'h0000_0000_0000_0001);           // subnormal
		send_request(64'h000F_FFFF_FFFF_FFFF);           // largest subnormal
		send_request(64'h7FF0_0000_0000_0000);           // infinity
		send_request(64'hFFF0_0000_0000_0000);           // -infinity
		send_request(64'h7FF8_0000_0000_0001);           // NaN
		send_request(make_double(0, 894, 0));            // lowest exponent
		send_request(make_double(0, 893, 52'hF_FFFF_FFFF_FFFF)); // just below
		send_request(make_double(0, 1149, 52'hF_FFFF_FFFF_FFFF)); // highest
		send_request(make_double(1, 1150, 0));           // just above
		send_request(make_double(0, 1000, 52'hF_FFFF_FFFF_FFFF)); // all-ones mantissa
		send_request(make_double(0, 1000, 52'hF_FFFF_FFEF_FFFF)); // all-ones mantissa, round bit clear
		send_request(64'h7FEF_FFFF_FFFF_FFFF);           // largest finite
		drain();
	endtask

	task automatic test_random(int n);
		logic [63:0] v;
		int          ef;
		for (int i = 0; i < n; i++) begin
			v = {$urandom, $urandom};
			case ($urandom_range(5))
				0: ef = $urandom_range(1023, 1038);
				1: ef = $urandom_range(880, 1160);
				2: ef = ($urandom_range(1) != 0) ? 0 : 2047;
				default: ef = -1;
			endcase
			if (ef >= 0)
				v[62:52] = 11'(ef);
			if ($urandom_range(3) == 0 && ef >= 1023 && ef <= 1038)
				v[51:0] = v[51:0] & ~((52'd1 << (52 - (ef - 1023))) - 52'd1);
			send_request(v);
		end
		drain();
	endtask

	task automatic test_backpressure();
		hold_req_cnt = hold_req_cnt + 1;
		for (int i = 0; i < 20; i++)
			send_request({$urandom, $urandom});
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		value_bits = 64'd0;
		hold_req_cnt = 0;
		send_idle_pct = 36;
		recv_idle_pct = 68;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(210);
		send_idle_pct = 0;
		test_backpressure();
		send_idle_pct = 68;
		recv_idle_pct = 36;
		test_random(210);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(210);
		drain();
		repeat (10) @(negedge clk);
		if (mismatch_cnt == 0 && pending_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
